>>> rtl/core/gradient_palette_pixel_mapper_defines.svh
// ---------------------------------------------------------------------------
// Gradient palette pixel mapper: assertion macros
// Shared concurrent assertion forms, all clocked on clk.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_PALETTE_PIXEL_MAPPER_DEFINES_SVH
`define GRADIENT_PALETTE_PIXEL_MAPPER_DEFINES_SVH

// same-cycle implication, off while rst is high
`define GPPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while rst is high
`define GPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define GPPM_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gppm_pkg.sv
// ---------------------------------------------------------------------------
// Gradient palette pixel mapper package
// Payload types, register indexes, palette constants and the root table.
// ---------------------------------------------------------------------------
package gppm_pkg;

  localparam int PALETTE_ENTRIES = 256;  // 128..256
  localparam int LOW_ENTRIES     = 64;
  localparam int CFG_WIDTH       = 32;

  localparam logic [7:0]  FULL_SCALE_RESET = 8'd63;
  localparam logic [31:0] REGEN_RESET      = 32'd10000;

  // fade: floor(n / FADE_DIV) as (n * FADE_RECIP) >> FADE_SHIFT, exact for 16-bit n
  localparam int FADE_NUM_W   = 16;
  localparam int FADE_DIV     = PALETTE_ENTRIES - LOW_ENTRIES;
  localparam int FADE_SHIFT   = FADE_NUM_W + $clog2(FADE_DIV);
  localparam int FADE_RECIP   = ((2 ** FADE_SHIFT) + FADE_DIV - 1) / FADE_DIV;
  localparam int FADE_RECIP_W = 17;
  localparam int FADE_PROD_W  = FADE_NUM_W + FADE_RECIP_W;

  typedef enum logic [1:0] {
    KIND_PURPLE = 2'd0,
    KIND_GREEN  = 2'd1,
    KIND_AMBER  = 2'd2,
    KIND_FROSTY = 2'd3
  } kind_t;

  typedef enum logic {
    REG_FULL_SCALE     = 1'b0,
    REG_REGEN_INTERVAL = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic        first_of_frame;
    logic [31:0] current_time_ms;
    logic        energy_spike;
    logic [1:0]  random_kind;
  } gppm_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       palette_changed;
  } gppm_out_t;

  // floor(8 * sqrt(a)) for a in 0..63
  localparam logic [5:0] ROOT8 [LOW_ENTRIES] = '{
    6'd0,  6'd8,  6'd11, 6'd13, 6'd16, 6'd17, 6'd19, 6'd21,
    6'd22, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
    6'd32, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
    6'd39, 6'd40, 6'd40, 6'd41, 6'd42, 6'd43, 6'd43, 6'd44,
    6'd45, 6'd45, 6'd46, 6'd47, 6'd48, 6'd48, 6'd49, 6'd49,
    6'd50, 6'd51, 6'd51, 6'd52, 6'd53, 6'd53, 6'd54, 6'd54,
    6'd55, 6'd56, 6'd56, 6'd57, 6'd57, 6'd58, 6'd58, 6'd59,
    6'd59, 6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62, 6'd63
  };

endpackage

>>> rtl/core/gradient_palette_pixel_mapper.sv
// ---------------------------------------------------------------------------
// Gradient palette pixel mapper
// Maps one pixel intensity per word to red, green and blue from one of four
// computed gradient palettes, switching palette on energy spikes.
// ---------------------------------------------------------------------------
// Takes one pixel word per clock unless the output stalls, and returns one
// color word per pixel, in order. A pixel taken is held in the first stage,
// then its color word in the output register: the first stage makes the
// palette decision and the low-index colors, the second runs the fade divide
// as a reciprocal multiply. Both stages advance together whenever the output
// register is free, so the sustained rate is one pixel per clock; a stalled
// output still lets one more pixel into the first stage. On a pixel flagged
// first_of_frame the palette kind is replaced by random_kind if no kind was
// ever chosen, or if energy_spike is set and more than regen_interval_ms has
// passed (mod 2^32) since the last change; that pixel is already mapped with
// the new kind and flags palette_changed. Write the full-scale color and
// regen interval registers only while the block is idle.
// ---------------------------------------------------------------------------
module gradient_palette_pixel_mapper (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gppm_pkg::gppm_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gppm_pkg::gppm_out_t        out_data,
  input  logic                       cfg_we,
  input  gppm_pkg::reg_idx_t         cfg_index,
  input  logic [gppm_pkg::CFG_WIDTH-1:0] cfg_data
);
  import gppm_pkg::*;

  // configuration
  logic [7:0]  full_scale;
  logic [31:0] regen_interval_ms;

  // palette selection state
  kind_t       palette_kind;
  logic [31:0] last_change_time;
  logic        chosen;  // a kind was taken at least once

  // handshake
  logic in_fire;
  logic out_free;

  // stage 1 comb
  logic [31:0]           elapsed;
  logic                  change;
  kind_t                 kind_eff;
  logic [5:0]            a_low;
  logic [11:0]           a_sq;
  logic [7:0]            t_lin;
  logic [7:0]            t_sq;
  logic [7:0]            t_rt;
  logic                  is_low;
  logic                  beyond;
  logic [8:0]            span;
  logic [FADE_NUM_W-1:0] fade_num;
  logic [7:0]            r_next;
  logic [7:0]            g_next;
  logic [7:0]            b_next;
  logic                  fade_next;

  // stage 1 registers
  logic                  s1_valid;
  logic [7:0]            s1_red;
  logic [7:0]            s1_green;
  logic [7:0]            s1_blue;
  logic                  s1_fade;
  logic [FADE_NUM_W-1:0] s1_num;
  logic                  s1_changed;

  // stage 2 comb
  logic [FADE_PROD_W-1:0] fade_prod;
  logic [7:0]             fade_q;
  gppm_out_t              out_next;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // ---- palette decision, made against the state before this pixel ----
  assign elapsed = in_data.current_time_ms - last_change_time;
  assign change  = in_data.first_of_frame &&
                   (!chosen || (in_data.energy_spike && (elapsed > regen_interval_ms)));
  assign kind_eff = change ? kind_t'(in_data.random_kind) : palette_kind;

  // ---- the three low-index terms ----
  assign a_low  = in_data.pixel_index[5:0];
  assign a_sq   = 12'(a_low) * 12'(a_low);
  assign t_lin  = {2'b00, a_low};
  assign t_sq   = {2'b00, a_sq[11:6]};
  assign t_rt   = {2'b00, ROOT8[a_low]};
  assign is_low = in_data.pixel_index < 8'(LOW_ENTRIES);
  assign beyond = {1'b0, in_data.pixel_index} >= 9'(PALETTE_ENTRIES);

  // fade numerator; span fits 8 bits whenever the fade is selected
  assign span     = 9'(PALETTE_ENTRIES) - {1'b0, in_data.pixel_index};
  assign fade_num = FADE_NUM_W'(span[7:0]) * FADE_NUM_W'(full_scale);

  always_comb begin
    r_next    = full_scale;
    g_next    = full_scale;
    b_next    = full_scale;
    fade_next = 1'b0;
    if (beyond) begin
      r_next = '0;
      g_next = '0;
      b_next = '0;
    end else if (is_low) begin
      case (kind_eff)
        KIND_PURPLE: begin
          r_next = t_lin; g_next = t_sq;  b_next = t_rt;
        end
        KIND_GREEN: begin
          r_next = t_sq;  g_next = t_rt;  b_next = t_lin;
        end
        KIND_AMBER: begin
          r_next = t_rt;  g_next = t_lin; b_next = t_sq;
        end
        default: begin
          r_next = t_sq;  g_next = t_lin; b_next = t_rt;
        end
      endcase
    end else if (kind_eff == KIND_AMBER) begin
      fade_next = 1'b1;
    end
  end

  // ---- config and palette state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale        <= FULL_SCALE_RESET;
      regen_interval_ms <= REGEN_RESET;
      palette_kind      <= KIND_PURPLE;
      last_change_time  <= '0;
      chosen            <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_SCALE:     full_scale        <= cfg_data[7:0];
          REG_REGEN_INTERVAL: regen_interval_ms <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_fire && change) begin
        palette_kind     <= kind_t'(in_data.random_kind);
        last_change_time <= in_data.current_time_ms;
        chosen           <= 1'b1;
      end
    end
  end

  // ---- stage 1 register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_red     <= r_next;
      s1_green   <= g_next;
      s1_blue    <= b_next;
      s1_fade    <= fade_next;
      s1_num     <= fade_num;
      s1_changed <= change;
    end
  end

  // ---- stage 2: fade divide by reciprocal, exact over the numerator range ----
  assign fade_prod = FADE_PROD_W'(s1_num) * FADE_PROD_W'(FADE_RECIP);
  assign fade_q    = fade_prod[FADE_SHIFT+7:FADE_SHIFT];

  always_comb begin
    out_next.red             = s1_fade ? fade_q : s1_red;
    out_next.green           = s1_fade ? fade_q : s1_green;
    out_next.blue            = s1_fade ? fade_q : s1_blue;
    out_next.palette_changed = s1_changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data <= out_next;
    end
  end

endmodule

>>> rtl/core/gppm_checker.sv
// ---------------------------------------------------------------------------
// Gradient palette pixel mapper checker
// Port-level assertions on flow control, bound to the top level.
// ---------------------------------------------------------------------------
`include "gradient_palette_pixel_mapper_defines.svh"

module gppm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gppm_pkg::gppm_out_t out_data
);
  import gppm_pkg::*;

  `GPPM_ASSERT_NEXT_RST(a_reset_empty, rst, !out_valid, "result shown right after reset")
  `GPPM_ASSERT_NOW(a_ready_flows, out_ready, in_ready, "input blocked while output drains")
  `GPPM_ASSERT_NEXT(a_fill_stalls, out_valid && !out_ready && in_valid && in_ready, out_ready || !in_ready, "pipe overfilled under stall")
  `GPPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind gradient_palette_pixel_mapper gppm_checker u_gppm_checker (.*);
